// ===== src/mer_pkg.sv =====
// Shared types, microcode format and the microprogram of the ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    // Width of the microprogram counter.
    localparam int PC_W = 6;

    // Request kinds carried in the input tuser bit.
    typedef enum logic
    {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } req_t;

    // Multiplier operand selects.
    typedef enum logic [3:0]
    {
        OP_ZERO,
        OP_ONE,
        OP_RX,
        OP_RY,
        OP_RXSQ,
        OP_RYSQ,
        OP_X,
        OP_Y,
        OP_TMP,
        OP_ATERM,
        OP_BTERM
    } opnd_t;

    // Decision register operations on the shifted product.
    typedef enum logic [1:0]
    {
        DEC_HOLD,
        DEC_LOAD,
        DEC_ADD,
        DEC_SUB
    } dec_op_t;

    // Product scaling before it reaches the decision register.
    typedef enum logic [1:0]
    {
        SH_0,
        SH_2,
        SH_3
    } shift_t;

    // Jump conditions.
    typedef enum logic [2:0]
    {
        C_NONE,
        C_ALWAYS,
        C_IDLE,
        C_FIRST,
        C_R2,
        C_R1_EXIT,
        C_NEG,
        C_NOT_POS
    } cond_t;

    // One control word. All-zero means: do nothing.
    typedef struct packed
    {
        opnd_t            mul_a;
        opnd_t            mul_b;
        dec_op_t          dec_op;
        shift_t           dec_sh;
        logic             tmp_ld;
        logic             rxsq_ld;
        logic             rysq_ld;
        logic             x_inc;
        logic             y_dec;
        logic             set_r2;
        logic             emit;
        logic             done;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    // Datapath flags seen by the sequencer.
    typedef struct packed
    {
        logic walking;
        logic first;
        logic r2;
        logic dec_neg;
        logic dec_pos;
        logic r1_exit;
        logic out_free;
    } status_t;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_START    = 6'd0;
    localparam logic [PC_W-1:0] PC_ADV      = 6'd6;
    localparam logic [PC_W-1:0] PC_R1_TEST  = 6'd8;
    localparam logic [PC_W-1:0] PC_R1_STEP  = 6'd11;
    localparam logic [PC_W-1:0] PC_R1_NEG   = 6'd16;
    localparam logic [PC_W-1:0] PC_R2_INIT  = 6'd18;
    localparam logic [PC_W-1:0] PC_R2_STEP  = 6'd24;
    localparam logic [PC_W-1:0] PC_R2_XSTEP = 6'd28;
    localparam logic [PC_W-1:0] PC_EMIT     = 6'd33;
    localparam logic [PC_W-1:0] PC_QUIT     = 6'd34;

    // Microprogram. The product issued in one word is consumed by the next.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            // start: squares, then 4*ry^2 - 4*rx^2*ry + rx^2
            PC_START:
            begin
                w.mul_a = OP_RX;   w.mul_b = OP_RX;
            end
            PC_START + 6'd1:
            begin
                w.rxsq_ld = 1'b1;
                w.mul_a = OP_RY;   w.mul_b = OP_RY;
            end
            PC_START + 6'd2:
            begin
                w.rysq_ld = 1'b1;
                w.mul_a = OP_RXSQ; w.mul_b = OP_ONE;
            end
            PC_START + 6'd3:
            begin
                w.dec_op = DEC_LOAD; w.dec_sh = SH_0;
                w.mul_a = OP_RXSQ;   w.mul_b = OP_RY;
            end
            PC_START + 6'd4:
            begin
                w.dec_op = DEC_SUB;  w.dec_sh = SH_2;
                w.mul_a = OP_RYSQ;   w.mul_b = OP_ONE;
            end
            PC_START + 6'd5:
            begin
                w.dec_op = DEC_ADD;  w.dec_sh = SH_2;
                w.done = 1'b1;
            end
            // advance: dispatch
            PC_ADV:
            begin
                w.cond = C_IDLE;  w.target = PC_QUIT;
            end
            PC_ADV + 6'd1:
            begin
                w.cond = C_FIRST; w.target = PC_EMIT;
            end
            PC_R1_TEST:
            begin
                w.cond = C_R2;    w.target = PC_R2_STEP;
                w.mul_a = OP_RYSQ; w.mul_b = OP_X;
            end
            PC_R1_TEST + 6'd1:
            begin
                w.tmp_ld = 1'b1;
                w.mul_a = OP_RXSQ; w.mul_b = OP_Y;
            end
            PC_R1_TEST + 6'd2:
            begin
                w.cond = C_R1_EXIT; w.target = PC_R2_INIT;
            end
            // region one step
            PC_R1_STEP:
            begin
                w.x_inc = 1'b1;
            end
            PC_R1_STEP + 6'd1:
            begin
                w.mul_a = OP_RYSQ; w.mul_b = OP_X;
                w.cond = C_NEG;    w.target = PC_R1_NEG;
            end
            PC_R1_STEP + 6'd2:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_3;
                w.y_dec = 1'b1;
                w.mul_a = OP_RYSQ;  w.mul_b = OP_ONE;
            end
            PC_R1_STEP + 6'd3:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_2;
                w.mul_a = OP_RXSQ;  w.mul_b = OP_Y;
            end
            PC_R1_STEP + 6'd4:
            begin
                w.dec_op = DEC_SUB; w.dec_sh = SH_3;
                w.cond = C_ALWAYS;  w.target = PC_EMIT;
            end
            PC_R1_NEG:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_3;
                w.mul_a = OP_RYSQ;  w.mul_b = OP_ONE;
            end
            PC_R1_NEG + 6'd1:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_2;
                w.cond = C_ALWAYS;  w.target = PC_EMIT;
            end
            // region two entry: ry^2*a^2 + 4*rx^2*b^2 - 4*rx^2*ry^2
            PC_R2_INIT:
            begin
                w.set_r2 = 1'b1;
                w.mul_a = OP_ATERM; w.mul_b = OP_ATERM;
            end
            PC_R2_INIT + 6'd1:
            begin
                w.tmp_ld = 1'b1;
                w.mul_a = OP_BTERM; w.mul_b = OP_BTERM;
            end
            PC_R2_INIT + 6'd2:
            begin
                w.tmp_ld = 1'b1;
                w.mul_a = OP_RYSQ;  w.mul_b = OP_TMP;
            end
            PC_R2_INIT + 6'd3:
            begin
                w.dec_op = DEC_LOAD; w.dec_sh = SH_0;
                w.mul_a = OP_RXSQ;   w.mul_b = OP_TMP;
            end
            PC_R2_INIT + 6'd4:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_2;
                w.mul_a = OP_RXSQ;  w.mul_b = OP_RYSQ;
            end
            PC_R2_INIT + 6'd5:
            begin
                w.dec_op = DEC_SUB; w.dec_sh = SH_2;
            end
            // region two step
            PC_R2_STEP:
            begin
                w.y_dec = 1'b1;
                w.cond = C_NOT_POS; w.target = PC_R2_XSTEP;
            end
            PC_R2_STEP + 6'd1:
            begin
                w.mul_a = OP_RXSQ;  w.mul_b = OP_ONE;
            end
            PC_R2_STEP + 6'd2:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_2;
                w.mul_a = OP_RXSQ;  w.mul_b = OP_Y;
            end
            PC_R2_STEP + 6'd3:
            begin
                w.dec_op = DEC_SUB; w.dec_sh = SH_3;
                w.cond = C_ALWAYS;  w.target = PC_EMIT;
            end
            PC_R2_XSTEP:
            begin
                w.x_inc = 1'b1;
            end
            PC_R2_XSTEP + 6'd1:
            begin
                w.mul_a = OP_RYSQ;  w.mul_b = OP_X;
            end
            PC_R2_XSTEP + 6'd2:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_3;
                w.mul_a = OP_RXSQ;  w.mul_b = OP_Y;
            end
            PC_R2_XSTEP + 6'd3:
            begin
                w.dec_op = DEC_SUB; w.dec_sh = SH_3;
                w.mul_a = OP_RXSQ;  w.mul_b = OP_ONE;
            end
            PC_R2_XSTEP + 6'd4:
            begin
                w.dec_op = DEC_ADD; w.dec_sh = SH_2;
            end
            PC_EMIT:
            begin
                w.emit = 1'b1;
                w.done = 1'b1;
            end
            PC_QUIT:
            begin
                w.done = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/mer_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup and jumps.
`timescale 1ns / 1ps

module mer_sequencer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    output logic              load,
    input  mer_pkg::status_t  stat,
    output mer_pkg::ucode_t   ctl
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [mer_pkg::PC_W-1:0]  pc_reg;
    logic [mer_pkg::PC_W-1:0]  pc_next;
    mer_pkg::ucode_t           word;
    logic                      blocked;
    logic                      take;
    logic                      jump;

    assign word     = mer_pkg::ucode_rom(pc_reg);
    assign blocked  = word.emit && !stat.out_free;
    assign in_ready = !busy_reg;
    assign take     = in_valid && !busy_reg;
    assign load     = take && (mer_pkg::req_t'(in_kind) == mer_pkg::REQ_START);
    assign ctl      = (busy_reg && !blocked) ? word : '0;

    always_comb
    begin
        case (word.cond)
            mer_pkg::C_NONE:    jump = 1'b0;
            mer_pkg::C_ALWAYS:  jump = 1'b1;
            mer_pkg::C_IDLE:    jump = !stat.walking;
            mer_pkg::C_FIRST:   jump = stat.first;
            mer_pkg::C_R2:      jump = stat.r2;
            mer_pkg::C_R1_EXIT: jump = stat.r1_exit;
            mer_pkg::C_NEG:     jump = stat.dec_neg;
            mer_pkg::C_NOT_POS: jump = !stat.dec_pos;
            default:            jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (take)
        begin
            busy_next = 1'b1;
            pc_next   = (mer_pkg::req_t'(in_kind) == mer_pkg::REQ_START)
                        ? mer_pkg::PC_START : mer_pkg::PC_ADV;
        end
        else if (busy_reg && !blocked)
        begin
            if (word.done)
            begin
                busy_next = 1'b0;
            end
            else if (jump)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= mer_pkg::PC_START;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

// ===== src/mer_datapath.sv =====
// Datapath: shared multiplier, decision accumulator, walk registers, output register.
`timescale 1ns / 1ps

module mer_datapath
#(
    parameter int RADIUS_BITS = 8,
    parameter int COORD_BITS  = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius_x,
    input  logic [RADIUS_BITS-1:0] radius_y,
    input  mer_pkg::ucode_t        ctl,
    output mer_pkg::status_t       stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [COORD_BITS:0]    col_plus,
    output logic [COORD_BITS:0]    col_minus,
    output logic [COORD_BITS:0]    row_plus,
    output logic [COORD_BITS:0]    row_minus,
    output logic                   last_point
);

    localparam int XW  = RADIUS_BITS + 1;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int OPW = 2 * RADIUS_BITS + 4;
    localparam int DW  = 2 * OPW;
    localparam int OW  = COORD_BITS + 1;

    // control state
    logic walking_reg, walking_next;
    logic first_reg, first_next;
    logic r2_reg, r2_next;
    logic out_valid_reg, out_valid_next;

    // working registers
    logic [COORD_BITS-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [RADIUS_BITS-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [SQW-1:0]         rxsq_reg, rxsq_next, rysq_reg, rysq_next;
    logic [XW-1:0]          x_reg, x_next, y_reg, y_next;
    logic signed [DW-1:0]   dec_reg, dec_next;
    logic [DW-1:0]          tmp_reg, tmp_next;
    logic [DW-1:0]          prod_reg, prod_next;
    logic [OW-1:0]          cp_reg, cp_next, cm_reg, cm_next;
    logic [OW-1:0]          rp_reg, rp_next, rm_reg, rm_next;
    logic                   last_reg, last_next;

    logic [OPW-1:0]         opa;
    logic [OPW-1:0]         opb;
    logic [XW:0]            a_term;
    logic [XW-1:0]          b_term;
    logic [DW-1:0]          sh_val;

    assign a_term = {x_reg, 1'b1};
    assign b_term = y_reg - 1'b1;

    always_comb
    begin
        case (ctl.mul_a)
            mer_pkg::OP_ONE:   opa = OPW'(1);
            mer_pkg::OP_RX:    opa = OPW'(rx_reg);
            mer_pkg::OP_RY:    opa = OPW'(ry_reg);
            mer_pkg::OP_RXSQ:  opa = OPW'(rxsq_reg);
            mer_pkg::OP_RYSQ:  opa = OPW'(rysq_reg);
            mer_pkg::OP_X:     opa = OPW'(x_reg);
            mer_pkg::OP_Y:     opa = OPW'(y_reg);
            mer_pkg::OP_TMP:   opa = tmp_reg[OPW-1:0];
            mer_pkg::OP_ATERM: opa = OPW'(a_term);
            mer_pkg::OP_BTERM: opa = OPW'(b_term);
            default:           opa = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.mul_b)
            mer_pkg::OP_ONE:   opb = OPW'(1);
            mer_pkg::OP_RX:    opb = OPW'(rx_reg);
            mer_pkg::OP_RY:    opb = OPW'(ry_reg);
            mer_pkg::OP_RXSQ:  opb = OPW'(rxsq_reg);
            mer_pkg::OP_RYSQ:  opb = OPW'(rysq_reg);
            mer_pkg::OP_X:     opb = OPW'(x_reg);
            mer_pkg::OP_Y:     opb = OPW'(y_reg);
            mer_pkg::OP_TMP:   opb = tmp_reg[OPW-1:0];
            mer_pkg::OP_ATERM: opb = OPW'(a_term);
            mer_pkg::OP_BTERM: opb = OPW'(b_term);
            default:           opb = '0;
        endcase
    end

    always_comb
    begin
        case (ctl.dec_sh)
            mer_pkg::SH_2: sh_val = prod_reg << 2;
            mer_pkg::SH_3: sh_val = prod_reg << 3;
            default:       sh_val = prod_reg;
        endcase
    end

    always_comb
    begin
        walking_next   = walking_reg;
        first_next     = first_reg;
        r2_next        = r2_reg;
        out_valid_next = out_valid_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rxsq_next      = rxsq_reg;
        rysq_next      = rysq_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dec_next       = dec_reg;
        tmp_next       = tmp_reg;
        prod_next      = opa * opb;
        cp_next        = cp_reg;
        cm_next        = cm_reg;
        rp_next        = rp_reg;
        rm_next        = rm_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            cx_next      = center_x;
            cy_next      = center_y;
            rx_next      = radius_x;
            ry_next      = radius_y;
            x_next       = '0;
            y_next       = XW'(radius_y);
            r2_next      = 1'b0;
            walking_next = 1'b1;
            first_next   = 1'b1;
        end

        if (ctl.rxsq_ld)
        begin
            rxsq_next = prod_reg[SQW-1:0];
        end
        if (ctl.rysq_ld)
        begin
            rysq_next = prod_reg[SQW-1:0];
        end
        if (ctl.tmp_ld)
        begin
            tmp_next = prod_reg;
        end
        if (ctl.x_inc)
        begin
            x_next = x_reg + 1'b1;
        end
        if (ctl.y_dec)
        begin
            y_next = y_reg - 1'b1;
        end
        if (ctl.set_r2)
        begin
            r2_next = 1'b1;
        end

        case (ctl.dec_op)
            mer_pkg::DEC_LOAD: dec_next = $signed(sh_val);
            mer_pkg::DEC_ADD:  dec_next = dec_reg + $signed(sh_val);
            mer_pkg::DEC_SUB:  dec_next = dec_reg - $signed(sh_val);
            default:           dec_next = dec_reg;
        endcase

        // emit the current point; the point on the axis ends the walk
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            cp_next        = OW'(cx_reg) + OW'(x_reg);
            cm_next        = OW'(cx_reg) - OW'(x_reg);
            rp_next        = OW'(cy_reg) + OW'(y_reg);
            rm_next        = OW'(cy_reg) - OW'(y_reg);
            last_next      = (y_reg == '0);
            first_next     = 1'b0;
            if (y_reg == '0)
            begin
                walking_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg   <= 1'b0;
            first_reg     <= 1'b0;
            r2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            walking_reg   <= walking_next;
            first_reg     <= first_next;
            r2_reg        <= r2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rxsq_reg <= rxsq_next;
        rysq_reg <= rysq_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        dec_reg  <= dec_next;
        tmp_reg  <= tmp_next;
        prod_reg <= prod_next;
        cp_reg   <= cp_next;
        cm_reg   <= cm_next;
        rp_reg   <= rp_next;
        rm_reg   <= rm_next;
        last_reg <= last_next;
    end

    assign stat.walking  = walking_reg;
    assign stat.first    = first_reg;
    assign stat.r2       = r2_reg;
    assign stat.dec_neg  = dec_reg[DW-1];
    assign stat.dec_pos  = !dec_reg[DW-1] && (dec_reg != '0);
    assign stat.r1_exit  = (tmp_reg >= prod_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign col_plus   = cp_reg;
    assign col_minus  = cm_reg;
    assign row_plus   = rp_reg;
    assign row_minus  = rm_reg;
    assign last_point = last_reg;

endmodule

// ===== src/midpoint_ellipse_rasterizer_core.sv =====
// Top level of the microcoded midpoint ellipse rasterizer.
`timescale 1ns / 1ps

// Midpoint ellipse rasterizer, one quadrant walk mirrored to four points.
// Input channel (s_axis): tuser selects the request. A start item (tuser 0)
// latches center and radii and primes the walk at (0, radius_y); it gives
// no result. An advance item (tuser 1) gives the next point of the walk, or
// nothing when no walk is active.
// Output channel (m_axis): one item per producing advance, tdata carries the
// four mirrored coordinates, tlast marks the point on the horizontal axis,
// after which the walk is over until the next start.
// A start item keeps the block busy until its microprogram path ends. So
// does an advance item, whose path depends on the case: no walk active, the
// first point, a normal step, or the step that enters region two. The emit
// step writes the result into the output register and ends the path. All
// paths share one registered multiplier.
// s_axis_tready is high whenever the sequencer is idle, also while a result
// waits in the output register. If the receiver stalls, the next emit step
// holds until the output register drains; nothing is dropped.
// Reset clears the sequencer, the output valid and the walk flags: after
// reset advance items give no result until a start item arrives.
module midpoint_ellipse_rasterizer_core
#(
    parameter int RADIUS_BITS = 8,
    parameter int COORD_BITS  = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // center_x, center_y, radius_x, radius_y, zero pad
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // col_plus, col_minus, row_plus, row_minus, zero pad
    output logic [((4*(COORD_BITS+1)+7)/8)*8-1:0]           m_axis_tdata,
    // last_point
    output logic              m_axis_tlast
);

    localparam int OUT_W = ((4 * (COORD_BITS + 1) + 7) / 8) * 8;

    mer_pkg::ucode_t        ctl;
    mer_pkg::status_t       stat;
    logic                   load;
    logic [COORD_BITS:0]    col_plus;
    logic [COORD_BITS:0]    col_minus;
    logic [COORD_BITS:0]    row_plus;
    logic [COORD_BITS:0]    row_minus;

    // Step through the microprogram, one control word per cycle unless an emit step waits for the output register.
    mer_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .load     (load),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath unpacks the start fields straight from tdata.
    mer_datapath
    #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .center_x   (s_axis_tdata[COORD_BITS-1:0]),
        .center_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .radius_x   (s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
        .radius_y   (s_axis_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS]),
        .ctl        (ctl),
        .stat       (stat),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .col_plus   (col_plus),
        .col_minus  (col_minus),
        .row_plus   (row_plus),
        .row_minus  (row_minus),
        .last_point (m_axis_tlast)
    );

    // Pack the four coordinates, first field lowest.
    assign m_axis_tdata = OUT_W'({row_minus, row_plus, col_minus, col_plus});

`ifndef SYNTHESIS
    // an accepted item always leaves the sequencer busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while sequencer still free");

    // an emit step must never overwrite a result that is still held
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("emit while output register is full");

    // the primed first point only exists inside an active walk
    a_first_walk: assert property (@(posedge clk) disable iff (!rst_n)
        stat.first |-> stat.walking)
        else $error("first point pending without an active walk");
`endif

endmodule
